// File: sv/datediff_pkg.sv
// Package for the date difference unit: transaction structs, calendar
// constants and small calendar helper functions.
// No dependencies.
package datediff_pkg;

    localparam int unsigned DayW   = 5;
    localparam int unsigned MonthW = 4;
    localparam int unsigned YearW  = 14;
    localparam int unsigned CountW = 22;
    localparam int unsigned ModW   = 9;

    localparam logic [YearW-1:0]  YearMax   = YearW'(9999);
    localparam logic [YearW-1:0]  QuadCent  = YearW'(400);
    localparam logic [ModW-1:0]   QuadCentM = ModW'(399);
    localparam logic [MonthW-1:0] MonthJan  = MonthW'(1);
    localparam logic [MonthW-1:0] MonthFeb  = MonthW'(2);
    localparam logic [MonthW-1:0] MonthDec  = MonthW'(12);

    typedef struct packed {
        logic [DayW-1:0]   start_day;
        logic [MonthW-1:0] start_month;
        logic [YearW-1:0]  start_year;
        logic [DayW-1:0]   end_day;
        logic [MonthW-1:0] end_month;
        logic [YearW-1:0]  end_year;
        logic              include_end;
    } datediff_req_t;

    typedef struct packed {
        logic [CountW-1:0] day_count;
        logic              bad_date;
    } datediff_res_t;

    // Leap test from the year taken modulo 400.
    function automatic logic leap_from_mod(input logic [ModW-1:0] r);
        logic cent;
        cent = (r == ModW'(100)) || (r == ModW'(200)) || (r == ModW'(300));
        return (r == '0) || (!cent && (r[1:0] == 2'b00));
    endfunction

    function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                     input logic leap);
        logic [DayW-1:0] len;
        case (m)
            MonthFeb:                  len = leap ? DayW'(29) : DayW'(28);
            4'd4, 4'd6, 4'd9, 4'd11:   len = DayW'(30);
            default:                   len = DayW'(31);
        endcase
        return len;
    endfunction

    function automatic logic date_ok(input logic [DayW-1:0] d,
                                     input logic [MonthW-1:0] m,
                                     input logic [YearW-1:0] y,
                                     input logic leap);
        return (y != '0) && (y <= YearMax) && (m >= MonthJan) && (m <= MonthDec)
            && (d != '0) && (d <= month_length(m, leap));
    endfunction

endpackage

// File: sv/date_difference_in_days_unit.sv
// Top level of the Gregorian date difference unit.
// Depends on datediff_pkg for the transaction structs and calendar helpers.
//
// Usage: drive request and raise start while busy is low; the transaction is
// taken at that clock edge and busy rises on the next cycle. One result
// follows each request: done pulses high for exactly one cycle with result
// valid in that same cycle. The receiver cannot stall, so a result must be
// captured in the cycle done is high.
//
// Sequence: a shared 14-bit subtractor first reduces the end year and then
// the start year modulo 400 (one subtraction of 400 per cycle), a check
// state then checks both dates, and the walk then advances the date by one
// day per cycle, counting the days between the dates (up to 3652058).
// An invalid date ends the transaction right after the check. The next
// request may be issued in the cycle done is high.
//
// Reset (rst_n low, asynchronous) returns the sequencer to idle, clears
// done and the running count, and sets the walked date to January 1, year 1.
module date_difference_in_days_unit
    import datediff_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  datediff_req_t request,
    output logic          busy,
    output logic          done,
    output datediff_res_t result
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_RED_END   = 5'b00010,
        S_RED_START = 5'b00100,
        S_CHECK     = 5'b01000,
        S_WALK      = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    datediff_req_t     req_reg, req_next;
    logic [YearW-1:0]  rem_reg, rem_next;
    logic [ModW-1:0]   mod_reg, mod_next;
    logic              end_leap_reg, end_leap_next;
    logic [DayW-1:0]   walk_day_reg, walk_day_next;
    logic [MonthW-1:0] walk_month_reg, walk_month_next;
    logic [YearW-1:0]  walk_year_reg, walk_year_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              done_reg, done_next;
    datediff_res_t     result_reg, result_next;

    logic              rem_ge;
    logic [YearW-1:0]  rem_sub;
    logic              walk_leap;
    logic [DayW-1:0]   walk_len;
    logic              walk_before;

    // The single shared subtractor used for both modulo reductions.
    assign rem_ge  = (rem_reg >= QuadCent);
    assign rem_sub = rem_reg - QuadCent;

    assign walk_leap   = leap_from_mod(mod_reg);
    assign walk_len    = month_length(walk_month_reg, walk_leap);
    assign walk_before = {walk_year_reg, walk_month_reg, walk_day_reg}
                       < {req_reg.end_year, req_reg.end_month, req_reg.end_day};

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        rem_next        = rem_reg;
        mod_next        = mod_reg;
        end_leap_next   = end_leap_reg;
        walk_day_next   = walk_day_reg;
        walk_month_next = walk_month_reg;
        walk_year_next  = walk_year_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    rem_next   = request.end_year;
                    state_next = S_RED_END;
                end
            end
            S_RED_END:
            begin
                if (rem_ge)
                begin
                    rem_next = rem_sub;
                end
                else
                begin
                    end_leap_next = leap_from_mod(rem_reg[ModW-1:0]);
                    rem_next      = req_reg.start_year;
                    state_next    = S_RED_START;
                end
            end
            S_RED_START:
            begin
                if (rem_ge)
                begin
                    rem_next = rem_sub;
                end
                else
                begin
                    mod_next   = rem_reg[ModW-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                walk_day_next   = req_reg.start_day;
                walk_month_next = req_reg.start_month;
                walk_year_next  = req_reg.start_year;
                count_next      = '0;
                if (!date_ok(req_reg.start_day, req_reg.start_month,
                             req_reg.start_year, leap_from_mod(mod_reg))
                    || !date_ok(req_reg.end_day, req_reg.end_month,
                                req_reg.end_year, end_leap_reg))
                begin
                    result_next.day_count = '0;
                    result_next.bad_date  = 1'b1;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_before)
                begin
                    count_next = count_reg + CountW'(1);
                    if (walk_day_reg == walk_len)
                    begin
                        walk_day_next = DayW'(1);
                        if (walk_month_reg == MonthDec)
                        begin
                            walk_month_next = MonthJan;
                            walk_year_next  = walk_year_reg + YearW'(1);
                            mod_next = (mod_reg == QuadCentM) ? '0 : mod_reg + ModW'(1);
                        end
                        else
                        begin
                            walk_month_next = walk_month_reg + MonthW'(1);
                        end
                    end
                    else
                    begin
                        walk_day_next = walk_day_reg + DayW'(1);
                    end
                end
                else
                begin
                    count_next            = count_reg + CountW'(req_reg.include_end);
                    result_next.day_count = count_reg + CountW'(req_reg.include_end);
                    result_next.bad_date  = 1'b0;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            walk_day_reg   <= DayW'(1);
            walk_month_reg <= MonthJan;
            walk_year_reg  <= YearW'(1);
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            walk_day_reg   <= walk_day_next;
            walk_month_reg <= walk_month_next;
            walk_year_reg  <= walk_year_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rem_reg      <= rem_next;
        mod_reg      <= mod_next;
        end_leap_reg <= end_leap_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // A result is only ever presented once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // An invalid date always reports a zero count.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.bad_date) |-> (result.day_count == '0))
        else $error("bad date with nonzero count");

    // An accepted transaction makes the unit busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start the sequencer");

    // While walking, the running count never decreases.
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && $past(state_reg == S_WALK)) |->
        (count_reg >= $past(count_reg)))
        else $error("running count decreased during walk");
`endif

endmodule
